FILE: hdl/bpb_pkg.sv
// Shared types and constants for the path blend block.
// Used by every module under hdl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bpb_pkg;

    localparam int POINT_W         = 64;
    localparam int HALF_W          = 32;
    localparam int WEIGHT_W        = 20;
    localparam int WEIGHT_FRAC     = 16;
    localparam int COORD_W_DEFAULT = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 20'd32768;

    // configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_B = 1'b1;

    // node continuity codes
    localparam logic [1:0] CONT_ANGLE     = 2'd0;
    localparam logic [1:0] CONT_SMOOTH    = 2'd1;
    localparam logic [1:0] CONT_SYMMETRIC = 2'd2;

    // segment position codes
    localparam logic [1:0] POS_FIRST = 2'd0;
    localparam logic [1:0] POS_LAST  = 2'd2;
    localparam logic [1:0] POS_ONLY  = 2'd3;

    // one blend lane per output coordinate
    localparam int N_LANES     = 6;
    localparam int LANE_NODE_X = 0;
    localparam int LANE_NODE_Y = 1;
    localparam int LANE_C1_X   = 2;
    localparam int LANE_C1_Y   = 3;
    localparam int LANE_C2_X   = 4;
    localparam int LANE_C2_Y   = 5;

    typedef struct packed {
        logic       curve;
        logic [1:0] continuity;
        logic       last;
        logic       closed;
    } t_meta;

endpackage

`default_nettype wire

FILE: hdl/bpb_third.sv
// Pipelined third point: round((2*far + near) / 3), ties upward, in three stages.
// Divide by three is a reciprocal multiply split into four partial products.
// Depends on bpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpb_third
    import bpb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_W_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_far,
    input  logic signed [COORD_WIDTH-1:0] i_near,
    output logic signed [COORD_WIDTH-1:0] o_point
);

    localparam int ZW = COORD_WIDTH + 2;
    localparam int SW = COORD_WIDTH + 3;
    localparam int K  = ZW + 1;
    localparam int H  = (ZW + 1) / 2;
    localparam int PW = 2 * H;
    localparam int FW = 4 * H;
    localparam logic [63:0] RECIP = ((64'd1 << K) + 64'd2) / 64'd3;
    // offset keeps the dividend positive; removed again by flipping the top bit
    localparam logic signed [SW-1:0] BIAS = SW'((64'sd3 <<< (COORD_WIDTH - 1)) + 64'sd1);

    logic signed [SW-1:0]          n_sum;
    logic [ZW-1:0]                 r_z;
    logic [H-1:0]                  w_zl, w_zh, w_ml, w_mh;
    logic [PW-1:0]                 r_pll, r_plh, r_phl, r_phh;
    logic [FW-1:0]                 n_full;
    logic [COORD_WIDTH-1:0]        w_q;
    logic signed [COORD_WIDTH-1:0] r_point;

    assign n_sum = (SW'(i_far) <<< 1) + SW'(i_near) + BIAS;

    assign w_zl = r_z[H-1:0];
    assign w_zh = H'(r_z[ZW-1:H]);
    assign w_ml = RECIP[H-1:0];
    assign w_mh = H'(RECIP[ZW-1:H]);

    assign n_full = FW'(r_pll) + (FW'(r_plh) << H) + (FW'(r_phl) << H) + (FW'(r_phh) << PW);
    assign w_q    = n_full[K +: COORD_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z     <= n_sum[ZW-1:0];
            r_pll   <= PW'(w_zl) * PW'(w_ml);
            r_plh   <= PW'(w_zl) * PW'(w_mh);
            r_phl   <= PW'(w_zh) * PW'(w_ml);
            r_phh   <= PW'(w_zh) * PW'(w_mh);
            r_point <= signed'({~w_q[COORD_WIDTH-1], w_q[COORD_WIDTH-2:0]});
        end
    end

    assign o_point = r_point;

endmodule

`default_nettype wire

FILE: hdl/bpb_lane.sv
// One blend lane: weighted sum of two coordinates, rounded and saturated.
// Products are registered; rounding and clamping follow combinationally after them.
// Depends on bpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpb_lane
    import bpb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_W_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_coord_a,
    input  logic signed [COORD_WIDTH-1:0] i_coord_b,
    input  logic signed [WEIGHT_W-1:0]    i_weight_a,
    input  logic signed [WEIGHT_W-1:0]    i_weight_b,
    output logic signed [COORD_WIDTH-1:0] o_coord,
    output logic                          o_sat
);

    localparam int PW = COORD_WIDTH + WEIGHT_W;
    localparam int SW = PW + 1;
    localparam int RW = SW - WEIGHT_FRAC;
    localparam logic signed [SW-1:0] ROUND = SW'(64'sd1 <<< (WEIGHT_FRAC - 1));
    localparam logic signed [RW-1:0] C_MAX = RW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] C_MIN = RW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

    logic signed [PW-1:0] r_pa, r_pb;
    logic signed [SW-1:0] n_sum;
    logic signed [RW-1:0] w_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa <= PW'(i_coord_a) * PW'(i_weight_a);
            r_pb <= PW'(i_coord_b) * PW'(i_weight_b);
        end
    end

    assign n_sum = SW'(r_pa) + SW'(r_pb) + ROUND;
    assign w_res = signed'(n_sum[SW-1:WEIGHT_FRAC]);

    always_comb begin
        if (w_res > C_MAX) begin
            o_coord = C_MAX[COORD_WIDTH-1:0];
            o_sat   = 1'b1;
        end else if (w_res < C_MIN) begin
            o_coord = C_MIN[COORD_WIDTH-1:0];
            o_sat   = 1'b1;
        end else begin
            o_coord = w_res[COORD_WIDTH-1:0];
            o_sat   = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bpb_merge.sv
// Merge stage: packs the six lane results into points, folds the saturation
// flags and holds the output register with its handshake. Depends on bpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpb_merge
    import bpb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_W_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  t_meta                         i_meta,
    input  logic signed [COORD_WIDTH-1:0] i_coord [N_LANES],
    input  logic [N_LANES-1:0]            i_sat,
    input  logic                          i_out_ready,
    output logic                          o_advance,
    output logic                          o_out_valid,
    output logic [POINT_W-1:0]            o_out_node,
    output logic [POINT_W-1:0]            o_out_ctrl_one,
    output logic [POINT_W-1:0]            o_out_ctrl_two,
    output logic                          o_out_is_curve,
    output logic [1:0]                    o_out_continuity,
    output logic                          o_out_last,
    output logic                          o_out_closed,
    output logic                          o_out_saturated
);

    logic                r_valid;
    logic [POINT_W-1:0]  r_node, r_c1, r_c2;
    t_meta               r_meta;
    logic                r_sat;
    logic [POINT_W-1:0]  n_node, n_c1, n_c2;
    logic                n_sat;

    assign o_advance = !r_valid || i_out_ready;

    assign n_node = {HALF_W'(i_coord[LANE_NODE_X]), HALF_W'(i_coord[LANE_NODE_Y])};
    assign n_c1   = i_meta.curve ? {HALF_W'(i_coord[LANE_C1_X]), HALF_W'(i_coord[LANE_C1_Y])}
                                 : '0;
    assign n_c2   = i_meta.curve ? {HALF_W'(i_coord[LANE_C2_X]), HALF_W'(i_coord[LANE_C2_Y])}
                                 : '0;
    // control lanes only count when the result really is a curve
    assign n_sat  = i_sat[LANE_NODE_X] | i_sat[LANE_NODE_Y]
                  | (i_meta.curve & (i_sat[LANE_C1_X] | i_sat[LANE_C1_Y]
                                   | i_sat[LANE_C2_X] | i_sat[LANE_C2_Y]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_node <= n_node;
            r_c1   <= n_c1;
            r_c2   <= n_c2;
            r_meta <= i_meta;
            r_sat  <= n_sat;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_out_node       = r_node;
    assign o_out_ctrl_one   = r_c1;
    assign o_out_ctrl_two   = r_c2;
    assign o_out_is_curve   = r_meta.curve;
    assign o_out_continuity = r_meta.continuity;
    assign o_out_last       = r_meta.last;
    assign o_out_closed     = r_meta.closed;
    assign o_out_saturated  = r_sat;

endmodule

`default_nettype wire

FILE: hdl/bezier_path_blend.sv
// Path blend top level: blends one segment of each of two paths into one segment.
// Instantiates bpb_third, bpb_lane and bpb_merge; depends on bpb_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one segment pair per beat.
//   Output channel (o_out_valid / i_out_ready) gives one blended segment per beat.
//   Weights are written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// Timing:
//   A result passes the input register, three stages of the divide-by-three
//   unit that raises lines to curves, and one stage of blend products ahead
//   of the output register. Six lanes (x and y of node and both controls) run
//   side by side, so one beat per cycle is sustained while the output accepts;
//   the pipeline is set by the divider and the blend multipliers.
// Stall:
//   When the output beat is held, the whole pipeline freezes and o_in_ready
//   drops in the same cycle; nothing is lost or repeated.
// Reset:
//   Both weights return to 0.5, the stored previous nodes to zero, and the
//   pipeline empties; o_in_ready stays low while reset is held.
`timescale 1ns / 1ps
`default_nettype none

module bezier_path_blend
    import bpb_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_W_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WEIGHT_W-1:0]  i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [POINT_W-1:0]   i_a_node,
    input  logic [POINT_W-1:0]   i_a_ctrl_one,
    input  logic [POINT_W-1:0]   i_a_ctrl_two,
    input  logic [POINT_W-1:0]   i_b_node,
    input  logic [POINT_W-1:0]   i_b_ctrl_one,
    input  logic [POINT_W-1:0]   i_b_ctrl_two,
    input  logic                 i_a_is_curve,
    input  logic                 i_b_is_curve,
    input  logic [1:0]           i_a_continuity,
    input  logic [1:0]           i_b_continuity,
    input  logic [1:0]           i_segment_position,
    input  logic                 i_both_closed_equal,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [POINT_W-1:0]   o_out_node,
    output logic [POINT_W-1:0]   o_out_ctrl_one,
    output logic [POINT_W-1:0]   o_out_ctrl_two,
    output logic                 o_out_is_curve,
    output logic [1:0]           o_out_continuity,
    output logic                 o_out_last,
    output logic                 o_out_closed,
    output logic                 o_out_saturated
);

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;
    localparam int   N_CTRL = N_LANES - LANE_C1_X;

    typedef struct packed {
        logic [POINT_W-1:0] a_node;
        logic [POINT_W-1:0] a_c1;
        logic [POINT_W-1:0] a_c2;
        logic [POINT_W-1:0] b_node;
        logic [POINT_W-1:0] b_c1;
        logic [POINT_W-1:0] b_c2;
        logic               a_curve;
        logic               b_curve;
        t_meta              meta;
    } t_item;

    function automatic logic signed [COORD_WIDTH-1:0] f_crd(
        input logic [POINT_W-1:0] p,
        input logic               axis
    );
        return axis ? signed'(p[0 +: COORD_WIDTH]) : signed'(p[HALF_W +: COORD_WIDTH]);
    endfunction

    // code three reads as angle
    function automatic logic [1:0] f_cont(input logic [1:0] c);
        return (c == CONT_SMOOTH || c == CONT_SYMMETRIC) ? c : CONT_ANGLE;
    endfunction

    logic                          w_advance, w_accept, w_first;
    logic [1:0]                    w_cont_a, w_cont_b;
    logic signed [WEIGHT_W-1:0]    r_weight_a, r_weight_b;
    logic [POINT_W-1:0]            r_prev_a, r_prev_b;
    logic [POINT_W-1:0]            r_s0_prev_a, r_s0_prev_b;
    t_item                         n_s0, r_s0, r_d1, r_d2, r_d3;
    t_meta                         r_m4;
    logic [4:0]                    r_vld;
    logic signed [COORD_WIDTH-1:0] w_lane_a [N_LANES];
    logic signed [COORD_WIDTH-1:0] w_lane_b [N_LANES];
    logic signed [COORD_WIDTH-1:0] w_res    [N_LANES];
    logic [N_LANES-1:0]            w_sat;

    assign o_in_ready = w_advance && i_rst_n;
    assign w_accept   = i_in_valid && w_advance;

    assign w_first  = (i_segment_position == POS_FIRST) || (i_segment_position == POS_ONLY);
    assign w_cont_a = f_cont(i_a_continuity);
    assign w_cont_b = f_cont(i_b_continuity);

    always_comb begin
        n_s0.a_node          = i_a_node;
        n_s0.a_c1            = i_a_ctrl_one;
        n_s0.a_c2            = i_a_ctrl_two;
        n_s0.b_node          = i_b_node;
        n_s0.b_c1            = i_b_ctrl_one;
        n_s0.b_c2            = i_b_ctrl_two;
        n_s0.a_curve         = i_a_is_curve;
        n_s0.b_curve         = i_b_is_curve;
        n_s0.meta.curve      = !w_first && (i_a_is_curve || i_b_is_curve);
        n_s0.meta.continuity = (w_cont_a == w_cont_b) ? w_cont_a : CONT_ANGLE;
        n_s0.meta.last       = (i_segment_position == POS_LAST) ||
                               (i_segment_position == POS_ONLY);
        n_s0.meta.closed     = n_s0.meta.last && i_both_closed_equal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_a <= WEIGHT_RESET;
            r_weight_b <= WEIGHT_RESET;
            r_prev_a   <= '0;
            r_prev_b   <= '0;
            r_vld      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WEIGHT_A: r_weight_a <= i_cfg_data;
                    REG_WEIGHT_B: r_weight_b <= i_cfg_data;
                endcase
            end
            if (w_accept) begin
                r_prev_a <= i_a_node;
                r_prev_b <= i_b_node;
            end
            if (w_advance) begin
                r_vld <= {r_vld[3:0], i_in_valid};
            end
        end
    end

    // payload pipeline, frozen with the output register
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s0        <= n_s0;
            r_s0_prev_a <= r_prev_a;
            r_s0_prev_b <= r_prev_b;
            r_d1        <= r_s0;
            r_d2        <= r_d1;
            r_d3        <= r_d2;
            r_m4        <= r_d3.meta;
        end
    end

    assign w_lane_a[LANE_NODE_X] = f_crd(r_d3.a_node, AXIS_X);
    assign w_lane_a[LANE_NODE_Y] = f_crd(r_d3.a_node, AXIS_Y);
    assign w_lane_b[LANE_NODE_X] = f_crd(r_d3.b_node, AXIS_X);
    assign w_lane_b[LANE_NODE_Y] = f_crd(r_d3.b_node, AXIS_Y);

    // control lanes: a line side is raised from its previous node
    for (genvar k = 0; k < N_CTRL; k++) begin : g_ctrl
        localparam int   CTRL = k / 2;
        localparam logic AXIS = 1'(k % 2);

        logic signed [COORD_WIDTH-1:0] w_far_a, w_near_a, w_far_b, w_near_b;
        logic signed [COORD_WIDTH-1:0] w_third_a, w_third_b;
        logic [POINT_W-1:0]            w_given_a, w_given_b;

        if (CTRL == 0) begin : g_one
            assign w_far_a   = f_crd(r_s0_prev_a, AXIS);
            assign w_near_a  = f_crd(r_s0.a_node, AXIS);
            assign w_far_b   = f_crd(r_s0_prev_b, AXIS);
            assign w_near_b  = f_crd(r_s0.b_node, AXIS);
            assign w_given_a = r_d3.a_c1;
            assign w_given_b = r_d3.b_c1;
        end else begin : g_two
            assign w_far_a   = f_crd(r_s0.a_node, AXIS);
            assign w_near_a  = f_crd(r_s0_prev_a, AXIS);
            assign w_far_b   = f_crd(r_s0.b_node, AXIS);
            assign w_near_b  = f_crd(r_s0_prev_b, AXIS);
            assign w_given_a = r_d3.a_c2;
            assign w_given_b = r_d3.b_c2;
        end

        bpb_third #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_third_a (
            .i_clk   (i_clk),
            .i_en    (w_advance),
            .i_far   (w_far_a),
            .i_near  (w_near_a),
            .o_point (w_third_a)
        );

        bpb_third #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_third_b (
            .i_clk   (i_clk),
            .i_en    (w_advance),
            .i_far   (w_far_b),
            .i_near  (w_near_b),
            .o_point (w_third_b)
        );

        assign w_lane_a[LANE_C1_X + k] = r_d3.a_curve ? f_crd(w_given_a, AXIS) : w_third_a;
        assign w_lane_b[LANE_C1_X + k] = r_d3.b_curve ? f_crd(w_given_b, AXIS) : w_third_b;
    end

    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        bpb_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .i_clk      (i_clk),
            .i_en       (w_advance),
            .i_coord_a  (w_lane_a[l]),
            .i_coord_b  (w_lane_b[l]),
            .i_weight_a (r_weight_a),
            .i_weight_b (r_weight_b),
            .o_coord    (w_res[l]),
            .o_sat      (w_sat[l])
        );
    end

    bpb_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (r_vld[4]),
        .i_meta           (r_m4),
        .i_coord          (w_res),
        .i_sat            (w_sat),
        .i_out_ready      (i_out_ready),
        .o_advance        (w_advance),
        .o_out_valid      (o_out_valid),
        .o_out_node       (o_out_node),
        .o_out_ctrl_one   (o_out_ctrl_one),
        .o_out_ctrl_two   (o_out_ctrl_two),
        .o_out_is_curve   (o_out_is_curve),
        .o_out_continuity (o_out_continuity),
        .o_out_last       (o_out_last),
        .o_out_closed     (o_out_closed),
        .o_out_saturated  (o_out_saturated)
    );

endmodule

`default_nettype wire

FILE: sim/bpb_blend_checker.sv
// Scoreboard for the path blend block: tracks weight writes, predicts each blended segment.
// Compares every output beat in order; depends on bpb_pkg.
`timescale 1ns / 1ps

module bpb_blend_checker
    import bpb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WEIGHT_W-1:0]  i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [POINT_W-1:0]   i_a_node,
    input  logic [POINT_W-1:0]   i_a_ctrl_one,
    input  logic [POINT_W-1:0]   i_a_ctrl_two,
    input  logic [POINT_W-1:0]   i_b_node,
    input  logic [POINT_W-1:0]   i_b_ctrl_one,
    input  logic [POINT_W-1:0]   i_b_ctrl_two,
    input  logic                 i_a_is_curve,
    input  logic                 i_b_is_curve,
    input  logic [1:0]           i_a_continuity,
    input  logic [1:0]           i_b_continuity,
    input  logic [1:0]           i_segment_position,
    input  logic                 i_both_closed_equal,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [POINT_W-1:0]   i_out_node,
    input  logic [POINT_W-1:0]   i_out_ctrl_one,
    input  logic [POINT_W-1:0]   i_out_ctrl_two,
    input  logic                 i_out_is_curve,
    input  logic [1:0]           i_out_continuity,
    input  logic                 i_out_last,
    input  logic                 i_out_closed,
    input  logic                 i_out_saturated,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_curves,
    output int                   o_saturated
);

    localparam int     CW        = COORD_W_DEFAULT;
    localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (CW - 1));

    typedef struct packed {
        logic [POINT_W-1:0] node;
        logic [POINT_W-1:0] ctrl_one;
        logic [POINT_W-1:0] ctrl_two;
        logic               curve;
        logic [1:0]         continuity;
        logic               last;
        logic               closed;
        logic               saturated;
    } t_blend_seg;

    t_blend_seg         expected_segs[$];
    t_blend_seg         want;
    logic [WEIGHT_W-1:0] weight_a_q = WEIGHT_RESET;
    logic [WEIGHT_W-1:0] weight_b_q = WEIGHT_RESET;
    logic [POINT_W-1:0]  prev_a_q = '0;
    logic [POINT_W-1:0]  prev_b_q = '0;
    int fail_cnt   = 0;
    int checked    = 0;
    int curve_cnt  = 0;
    int sat_cnt    = 0;

    function automatic longint coord_of(logic [POINT_W-1:0] p, bit upper);
        logic [HALF_W-1:0] half;
        half = upper ? p[POINT_W-1:HALF_W] : p[HALF_W-1:0];
        return longint'($signed(half[CW-1:0]));
    endfunction

    // returns {clamped, coordinate}
    function automatic logic [HALF_W:0] blend_coord(longint ca, longint cb);
        longint acc;
        logic   sat;
        acc = ca * longint'($signed(weight_a_q)) + cb * longint'($signed(weight_b_q))
              + (longint'(1) <<< (WEIGHT_FRAC - 1));
        acc = acc >>> WEIGHT_FRAC;
        sat = 1'b0;
        if (acc > COORD_MAX) begin
            acc = COORD_MAX;
            sat = 1'b1;
        end else if (acc < COORD_MIN) begin
            acc = COORD_MIN;
            sat = 1'b1;
        end
        return {sat, acc[HALF_W-1:0]};
    endfunction

    // returns {clamped, packed point}
    function automatic logic [POINT_W:0] blend_point(logic [POINT_W-1:0] pa,
                                                     logic [POINT_W-1:0] pb);
        logic [HALF_W:0] x;
        logic [HALF_W:0] y;
        x = blend_coord(coord_of(pa, 1'b1), coord_of(pb, 1'b1));
        y = blend_coord(coord_of(pa, 1'b0), coord_of(pb, 1'b0));
        return {x[HALF_W] | y[HALF_W], x[HALF_W-1:0], y[HALF_W-1:0]};
    endfunction

    // round((2*far + near) / 3), ties up; floor division on a signed numerator
    function automatic longint third_of(longint far, longint near);
        longint t;
        longint q;
        t = 4 * far + 2 * near + 3;
        q = t / 6;
        if (t < 0 && (t % 6) != 0)
            q = q - 1;
        return q;
    endfunction

    // returns {ctrl_two, ctrl_one} of a line lifted to a cubic
    function automatic logic [2*POINT_W-1:0] lift_line(logic [POINT_W-1:0] prev,
                                                       logic [POINT_W-1:0] node);
        longint px, py, nx, ny;
        px = coord_of(prev, 1'b1);
        py = coord_of(prev, 1'b0);
        nx = coord_of(node, 1'b1);
        ny = coord_of(node, 1'b0);
        return {32'(third_of(nx, px)), 32'(third_of(ny, py)),
                32'(third_of(px, nx)), 32'(third_of(py, ny))};
    endfunction

    function automatic t_blend_seg blended_segment(
        logic [POINT_W-1:0] a_node, logic [POINT_W-1:0] a_c1, logic [POINT_W-1:0] a_c2,
        logic [POINT_W-1:0] b_node, logic [POINT_W-1:0] b_c1, logic [POINT_W-1:0] b_c2,
        logic a_curve, logic b_curve, logic [1:0] a_cont, logic [1:0] b_cont,
        logic [1:0] pos, logic closed);
        t_blend_seg        r;
        logic [POINT_W:0]  bp;
        logic [2*POINT_W-1:0] lifted;
        logic [1:0]        ca, cb;
        logic              first;
        ca = (a_cont > CONT_SYMMETRIC) ? CONT_ANGLE : a_cont;
        cb = (b_cont > CONT_SYMMETRIC) ? CONT_ANGLE : b_cont;
        first = (pos == POS_FIRST) || (pos == POS_ONLY);
        r = '0;
        r.last = (pos == POS_LAST) || (pos == POS_ONLY);
        r.closed = r.last & closed;
        r.continuity = (ca == cb) ? ca : CONT_ANGLE;
        bp = blend_point(a_node, b_node);
        r.node = bp[POINT_W-1:0];
        r.saturated = bp[POINT_W];
        if (!first && (a_curve || b_curve)) begin
            if (!a_curve) begin
                lifted = lift_line(prev_a_q, a_node);
                {a_c2, a_c1} = lifted;
            end
            if (!b_curve) begin
                lifted = lift_line(prev_b_q, b_node);
                {b_c2, b_c1} = lifted;
            end
            bp = blend_point(a_c1, b_c1);
            r.ctrl_one = bp[POINT_W-1:0];
            r.saturated |= bp[POINT_W];
            bp = blend_point(a_c2, b_c2);
            r.ctrl_two = bp[POINT_W-1:0];
            r.saturated |= bp[POINT_W];
            r.curve = 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [POINT_W-1:0] exp_v,
                               logic [POINT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            weight_a_q = WEIGHT_RESET;
            weight_b_q = WEIGHT_RESET;
            prev_a_q = '0;
            prev_b_q = '0;
            expected_segs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WEIGHT_A: weight_a_q = i_cfg_data;
                    REG_WEIGHT_B: weight_b_q = i_cfg_data;
                    default: ;
                endcase
            end
            // output side first: a beat accepted this edge cannot be the one leaving
            if (i_out_valid && i_out_ready) begin
                if (expected_segs.size() == 0) begin
                    $display("%0t: output beat with nothing expected, node %h",
                             $time, i_out_node);
                    fail_cnt++;
                end else begin
                    want = expected_segs.pop_front();
                    check_field("node", want.node, i_out_node);
                    check_field("ctrl_one", want.ctrl_one, i_out_ctrl_one);
                    check_field("ctrl_two", want.ctrl_two, i_out_ctrl_two);
                    check_field("is_curve", 64'(want.curve), 64'(i_out_is_curve));
                    check_field("continuity", 64'(want.continuity),
                                64'(i_out_continuity));
                    check_field("last", 64'(want.last), 64'(i_out_last));
                    check_field("closed", 64'(want.closed), 64'(i_out_closed));
                    check_field("saturated", 64'(want.saturated), 64'(i_out_saturated));
                    checked++;
                    if (want.curve)
                        curve_cnt++;
                    if (want.saturated)
                        sat_cnt++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_segs.push_back(blended_segment(
                    i_a_node, i_a_ctrl_one, i_a_ctrl_two,
                    i_b_node, i_b_ctrl_one, i_b_ctrl_two,
                    i_a_is_curve, i_b_is_curve, i_a_continuity, i_b_continuity,
                    i_segment_position, i_both_closed_equal));
                prev_a_q = i_a_node;
                prev_b_q = i_b_node;
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_segs.size();
        o_checked    <= checked;
        o_curves     <= curve_cnt;
        o_saturated  <= sat_cnt;
    end

endmodule

FILE: sim/bezier_path_blend_tb.sv
// Top of the path blend testbench: clock, reset, weight writes and segment stimulus.
// Instantiates bezier_path_blend and bpb_blend_checker; depends on bpb_pkg.
`timescale 1ns / 1ps

module bezier_path_blend_tb;
    import bpb_pkg::*;

    localparam logic [1:0] POS_MIDDLE    = 2'd1;
    localparam logic [1:0] CONT_RESERVED = 2'd3;

    localparam logic [WEIGHT_W-1:0] W_MAX  = 20'h7FFFF;
    localparam logic [WEIGHT_W-1:0] W_MIN  = 20'h80000;
    localparam logic [WEIGHT_W-1:0] W_ONE  = 20'h10000;
    localparam logic [WEIGHT_W-1:0] W_ZERO = 20'h00000;

    localparam logic [POINT_W-1:0] PT_MAX = 64'h7FFF_FFFF_7FFF_FFFF;
    localparam logic [POINT_W-1:0] PT_MIN = 64'h8000_0000_8000_0000;

    localparam int N_PHASES      = 11;
    localparam int PHASE_ITEMS   = 170;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RUN_LIMIT_NS  = 4_000_000;

    typedef struct packed {
        logic [POINT_W-1:0] a_node;
        logic [POINT_W-1:0] a_c1;
        logic [POINT_W-1:0] a_c2;
        logic [POINT_W-1:0] b_node;
        logic [POINT_W-1:0] b_c1;
        logic [POINT_W-1:0] b_c2;
        logic               a_curve;
        logic               b_curve;
        logic [1:0]         a_cont;
        logic [1:0]         b_cont;
        logic [1:0]         pos;
        logic               closed;
    } t_seg_pair;

    typedef enum {RX_FREE, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_WEIGHT_A;
    logic [WEIGHT_W-1:0]  i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [POINT_W-1:0]   i_a_node = '0;
    logic [POINT_W-1:0]   i_a_ctrl_one = '0;
    logic [POINT_W-1:0]   i_a_ctrl_two = '0;
    logic [POINT_W-1:0]   i_b_node = '0;
    logic [POINT_W-1:0]   i_b_ctrl_one = '0;
    logic [POINT_W-1:0]   i_b_ctrl_two = '0;
    logic                 i_a_is_curve = 1'b0;
    logic                 i_b_is_curve = 1'b0;
    logic [1:0]           i_a_continuity = CONT_ANGLE;
    logic [1:0]           i_b_continuity = CONT_ANGLE;
    logic [1:0]           i_segment_position = POS_FIRST;
    logic                 i_both_closed_equal = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [POINT_W-1:0]   o_out_node;
    logic [POINT_W-1:0]   o_out_ctrl_one;
    logic [POINT_W-1:0]   o_out_ctrl_two;
    logic                 o_out_is_curve;
    logic [1:0]           o_out_continuity;
    logic                 o_out_last;
    logic                 o_out_closed;
    logic                 o_out_saturated;

    int fail_count, pending_cnt, checked_cnt, curve_cnt, sat_cnt;
    int pairs_sent   = 0;
    int n_settings   = 1;
    int burst_left   = 1;
    bit no_gaps      = 1'b0;
    bit long_hold_req = 1'b0;

    bezier_path_blend u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_a_node            (i_a_node),
        .i_a_ctrl_one        (i_a_ctrl_one),
        .i_a_ctrl_two        (i_a_ctrl_two),
        .i_b_node            (i_b_node),
        .i_b_ctrl_one        (i_b_ctrl_one),
        .i_b_ctrl_two        (i_b_ctrl_two),
        .i_a_is_curve        (i_a_is_curve),
        .i_b_is_curve        (i_b_is_curve),
        .i_a_continuity      (i_a_continuity),
        .i_b_continuity      (i_b_continuity),
        .i_segment_position  (i_segment_position),
        .i_both_closed_equal (i_both_closed_equal),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_node          (o_out_node),
        .o_out_ctrl_one      (o_out_ctrl_one),
        .o_out_ctrl_two      (o_out_ctrl_two),
        .o_out_is_curve      (o_out_is_curve),
        .o_out_continuity    (o_out_continuity),
        .o_out_last          (o_out_last),
        .o_out_closed        (o_out_closed),
        .o_out_saturated     (o_out_saturated)
    );

    bpb_blend_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_a_node            (i_a_node),
        .i_a_ctrl_one        (i_a_ctrl_one),
        .i_a_ctrl_two        (i_a_ctrl_two),
        .i_b_node            (i_b_node),
        .i_b_ctrl_one        (i_b_ctrl_one),
        .i_b_ctrl_two        (i_b_ctrl_two),
        .i_a_is_curve        (i_a_is_curve),
        .i_b_is_curve        (i_b_is_curve),
        .i_a_continuity      (i_a_continuity),
        .i_b_continuity      (i_b_continuity),
        .i_segment_position  (i_segment_position),
        .i_both_closed_equal (i_both_closed_equal),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_out_node          (o_out_node),
        .i_out_ctrl_one      (o_out_ctrl_one),
        .i_out_ctrl_two      (o_out_ctrl_two),
        .i_out_is_curve      (o_out_is_curve),
        .i_out_continuity    (o_out_continuity),
        .i_out_last          (o_out_last),
        .i_out_closed        (o_out_closed),
        .i_out_saturated     (o_out_saturated),
        .o_fail_count        (fail_count),
        .o_pending           (pending_cnt),
        .o_checked           (checked_cnt),
        .o_curves            (curve_cnt),
        .o_saturated         (sat_cnt)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still outstanding", pending_cnt);
        $display("Verification failed");
        $finish;
    end

    // receiver: switches between stall patterns; a requested hold-off parks it once
    initial begin : out_side
        t_rx_mode mode;
        int left;
        int period;
        int cyc;
        bit held;
        mode = RX_FREE;
        left = 0;
        period = 2;
        cyc = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (long_hold_req && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    left = $urandom_range(40, 250);
                    period = $urandom_range(2, 5);
                end
                left--;
                case (mode)
                    RX_FREE:     i_out_ready <= 1'b1;
                    RX_MOSTLY:   i_out_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: i_out_ready <= ((cyc % period) == 0);
                    RX_SPARSE:   i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [HALF_W-1:0] rand_coord();
        logic [HALF_W-1:0] c;
        case ($urandom_range(0, 7))
            0, 1, 2: c = $urandom;
            3: begin
                c = $urandom_range(0, 2000);
                c = c - 32'd1000;
            end
            4: begin
                case ($urandom_range(0, 4))
                    0: c = 32'h7FFF_FFFF;
                    1: c = 32'h8000_0000;
                    2: c = 32'h0000_0000;
                    3: c = 32'hFFFF_FFFF;
                    default: c = 32'h0000_0001;
                endcase
            end
            default: begin
                c = $urandom;
                c = {{12{c[19]}}, c[19:0]};
            end
        endcase
        return c;
    endfunction

    function automatic logic [POINT_W-1:0] rand_point();
        return {rand_coord(), rand_coord()};
    endfunction

    function automatic t_seg_pair rand_pair(logic [1:0] pos);
        t_seg_pair s;
        s.a_node  = rand_point();
        s.a_c1    = rand_point();
        s.a_c2    = rand_point();
        s.b_node  = rand_point();
        s.b_c1    = rand_point();
        s.b_c2    = rand_point();
        s.a_curve = 1'($urandom_range(0, 1));
        s.b_curve = 1'($urandom_range(0, 1));
        s.a_cont  = 2'($urandom_range(0, 3));
        s.b_cont  = 2'($urandom_range(0, 3));
        s.pos     = pos;
        s.closed  = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic t_seg_pair fill_points(t_seg_pair s, logic [POINT_W-1:0] pa,
                                              logic [POINT_W-1:0] pb);
        s.a_node = pa;
        s.a_c1   = pa;
        s.a_c2   = pa;
        s.b_node = pb;
        s.b_c1   = pb;
        s.b_c2   = pb;
        return s;
    endfunction

    // holds the beat until accepted, then applies the burst/gap pacing
    task automatic offer_pair(t_seg_pair s);
        int g;
        i_in_valid          <= 1'b1;
        i_a_node            <= s.a_node;
        i_a_ctrl_one        <= s.a_c1;
        i_a_ctrl_two        <= s.a_c2;
        i_b_node            <= s.b_node;
        i_b_ctrl_one        <= s.b_c1;
        i_b_ctrl_two        <= s.b_c2;
        i_a_is_curve        <= s.a_curve;
        i_b_is_curve        <= s.b_curve;
        i_a_continuity      <= s.a_cont;
        i_b_continuity      <= s.b_cont;
        i_segment_position  <= s.pos;
        i_both_closed_equal <= s.closed;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pairs_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            g = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 8);
            if (g > 0) begin
                i_in_valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_weights(logic [WEIGHT_W-1:0] wa, logic [WEIGHT_W-1:0] wb);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_WEIGHT_A;
        i_cfg_data  <= wa;
        @(posedge i_clk);
        i_cfg_index <= REG_WEIGHT_B;
        i_cfg_data  <= wb;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    // mostly whole paths (first, middles, last or a lone segment), some loose segments
    task automatic send_paths(int n);
        t_seg_pair s;
        logic [1:0] pos;
        int done, len, k;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 9) < 2) begin
                s = rand_pair(2'($urandom_range(0, 3)));
                offer_pair(s);
                done++;
            end else begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    if (len == 1)
                        pos = POS_ONLY;
                    else if (k == 0)
                        pos = POS_FIRST;
                    else if (k == len - 1)
                        pos = POS_LAST;
                    else
                        pos = POS_MIDDLE;
                    s = rand_pair(pos);
                    offer_pair(s);
                    done++;
                end
            end
        end
    endtask

    initial begin : stimulus
        t_seg_pair s;
        int p;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset weights of one half each
        s = rand_pair(POS_MIDDLE);   // middle before any first: previous nodes are zero
        s.a_curve = 1'b0;
        s.b_curve = 1'b1;
        offer_pair(s);
        s = rand_pair(POS_MIDDLE);
        s.a_curve = 1'b0;
        s.b_curve = 1'b0;
        offer_pair(s);
        s = rand_pair(POS_FIRST);
        s.a_curve = 1'b1;
        s.b_curve = 1'b1;
        offer_pair(s);
        s = rand_pair(POS_MIDDLE);
        s.a_curve = 1'b1;
        s.b_curve = 1'b0;
        s.a_cont = CONT_SMOOTH;
        s.b_cont = CONT_SMOOTH;
        offer_pair(s);
        s = rand_pair(POS_MIDDLE);
        s.a_curve = 1'b1;
        s.b_curve = 1'b1;
        s.a_cont = CONT_SYMMETRIC;
        s.b_cont = CONT_SYMMETRIC;
        offer_pair(s);
        s = rand_pair(POS_LAST);
        s.a_curve = 1'b0;
        s.b_curve = 1'b0;
        s.closed = 1'b1;
        s.a_cont = CONT_RESERVED;    // reads as angle, so the pair agrees
        s.b_cont = CONT_ANGLE;
        offer_pair(s);
        s = rand_pair(POS_ONLY);
        s.a_curve = 1'b1;
        s.b_curve = 1'b1;
        s.closed = 1'b1;
        offer_pair(s);
        s = rand_pair(POS_MIDDLE);   // closed flag must not pass on a middle segment
        s.closed = 1'b1;
        s.a_cont = CONT_SMOOTH;
        s.b_cont = CONT_SYMMETRIC;
        offer_pair(s);
        s = rand_pair(POS_LAST);
        s.closed = 1'b0;
        s.a_cont = CONT_RESERVED;
        s.b_cont = CONT_RESERVED;
        offer_pair(s);
        s = rand_pair(POS_FIRST);    // half-way rounding ties on both signs
        s.a_node = {32'h0000_0001, 32'hFFFF_FFFF};
        s.b_node = '0;
        offer_pair(s);
        s = fill_points(rand_pair(POS_FIRST), PT_MAX, PT_MIN);
        offer_pair(s);
        s = fill_points(rand_pair(POS_MIDDLE), PT_MIN, PT_MAX);  // lift across full range
        s.a_curve = 1'b0;
        s.b_curve = 1'b1;
        offer_pair(s);
        s = fill_points(rand_pair(POS_LAST), '1, '1);
        s.a_curve = 1'b1;
        s.b_curve = 1'b1;
        offer_pair(s);
        s = fill_points(rand_pair(POS_FIRST), '0, '0);
        s.a_curve = 1'b0;
        s.b_curve = 1'b0;
        s.a_cont = CONT_ANGLE;
        s.b_cont = CONT_ANGLE;
        s.closed = 1'b0;
        offer_pair(s);

        // largest and smallest weights drive coordinates into clamping
        set_weights(W_MAX, W_MAX);
        s = fill_points(rand_pair(POS_MIDDLE), PT_MAX, PT_MAX);
        s.a_curve = 1'b1;
        s.b_curve = 1'b1;
        offer_pair(s);
        s = fill_points(rand_pair(POS_MIDDLE), PT_MIN, PT_MIN);
        s.a_curve = 1'b0;
        s.b_curve = 1'b1;
        offer_pair(s);
        s = fill_points(rand_pair(POS_LAST), PT_MAX, PT_MIN);
        offer_pair(s);
        offer_pair(rand_pair(POS_MIDDLE));
        set_weights(W_MIN, W_MIN);
        s = fill_points(rand_pair(POS_MIDDLE), PT_MAX, PT_MAX);
        s.a_curve = 1'b1;
        s.b_curve = 1'b0;
        offer_pair(s);
        s = fill_points(rand_pair(POS_MIDDLE), PT_MIN, PT_MIN);
        s.a_curve = 1'b1;
        s.b_curve = 1'b1;
        offer_pair(s);
        s = fill_points(rand_pair(POS_ONLY), PT_MIN, PT_MAX);
        offer_pair(s);
        offer_pair(rand_pair(POS_MIDDLE));

        // random phases, one weight setting each
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0:  set_weights(WEIGHT_RESET, WEIGHT_RESET);
                1:  set_weights(W_MAX, W_MAX);
                2:  set_weights(W_MIN, W_MIN);
                3:  set_weights(W_ZERO, W_ZERO);
                4:  set_weights(W_ONE, W_ZERO);
                5:  set_weights(W_ZERO, W_ONE);
                6:  set_weights(W_MIN, W_MAX);
                7:  set_weights(W_MAX, W_MIN);
                default: set_weights(WEIGHT_W'($urandom), WEIGHT_W'($urandom));
            endcase
            if (p == N_PHASES - 2) begin
                // back-to-back offers against a parked receiver fill the pipeline
                no_gaps = 1'b1;
                long_hold_req = 1'b1;
            end
            send_paths(PHASE_ITEMS);
            no_gaps = 1'b0;
        end

        drain();
        $display("Blended %0d segment pairs under %0d weight settings, incl. a long output stall",
                 pairs_sent, n_settings);
        $display("Results checked: %0d, curves: %0d, clamped: %0d",
                 checked_cnt, curve_cnt, sat_cnt);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bpb_pkg.sv
hdl/bpb_third.sv
hdl/bpb_lane.sv
hdl/bpb_merge.sv
hdl/bezier_path_blend.sv
sim/bpb_blend_checker.sv
sim/bezier_path_blend_tb.sv
